@@ hdl/hbp_pkg.sv @@
// hbp_pkg: shared types and constants for the huffman bit packer
// holds the action codes and the input and result item structs
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package hbp_pkg;

  localparam int DEF_MAX_CODE_BITS = 16;
  localparam int TABLE_DEPTH       = 256;
  localparam int SYM_W             = 8;
  localparam int CODE_W            = 16;
  localparam int LEN_W             = 5;

  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_ENCODE = 2'd1,
    ACT_FLUSH  = 2'd2
  } action_t;

  typedef struct packed {
    logic [1:0]        action;
    logic [SYM_W-1:0]  symbol;
    logic [CODE_W-1:0] code_word;
    logic [LEN_W-1:0]  code_length;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [3:0] valid_bits;
    logic       unknown_symbol;
    logic       last_of_run;
  } out_item_t;

endpackage

`default_nettype wire

@@ hdl/huffman_bit_packer.sv @@
// huffman_bit_packer: code table lookup and lsb-first byte packer
// depends on hbp_pkg (item structs, action codes, default code length)
//
//   channel | ports                          | payload
//   --------+--------------------------------+---------------------------
//   input   | in_valid, in_stall, in_item    | action, symbol, code, len
//   result  | out_valid, out_stall, out_item | byte, bits, unknown, last
//
// one item is accepted per cycle while in_stall is low; the code table read
// is registered, the packer stage works on the registered item and pushes
// 0..2 results into a four-entry output queue when it advances, and a result
// shows on the port once it is in the queue. an item yielding two bytes
// still enters as a single item, but the single result port drains them
// one per cycle while out_stall is low.
// reset clears the table valid bits, the packer and the queue at once;
// there is no clearing sweep. in_stall rises only while the packer stage
// is occupied and the queue has fewer than two free entries.
`timescale 1ns / 1ps
`default_nettype none

module huffman_bit_packer #(
  parameter int MAX_CODE_BITS = hbp_pkg::DEF_MAX_CODE_BITS
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire hbp_pkg::in_item_t in_item,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output hbp_pkg::out_item_t     out_item
);

  // stored code width: longer codes are saturated on load
  localparam int TAB_BITS_W = (MAX_CODE_BITS < hbp_pkg::CODE_W) ?
                              MAX_CODE_BITS : hbp_pkg::CODE_W;
  localparam logic [hbp_pkg::LEN_W-1:0] LEN_CAP = hbp_pkg::LEN_W'(TAB_BITS_W);
  localparam int ACC_W      = 8 + hbp_pkg::CODE_W;
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  // code table storage
  logic [TAB_BITS_W-1:0]     bits_mem [hbp_pkg::TABLE_DEPTH];
  logic [hbp_pkg::LEN_W-1:0] len_mem  [hbp_pkg::TABLE_DEPTH];
  logic [hbp_pkg::TABLE_DEPTH-1:0] tab_valid_r;

  // packer stage registers
  logic                      s1_valid_r;
  logic [1:0]                s1_action_r;
  logic                      s1_tvalid_r;
  logic [TAB_BITS_W-1:0]     s1_bits_r;
  logic [hbp_pkg::LEN_W-1:0] s1_len_r;
  logic                      s1_adv;

  // packer state
  logic [7:0] buf_r, buf_nxt;
  logic [2:0] fill_r, fill_nxt;

  // output queue
  hbp_pkg::out_item_t fifo_r [FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [1:0]         push_n;
  logic               pop;
  hbp_pkg::out_item_t res0, res1;

  logic                      in_accept;
  logic                      load_wr;
  logic [hbp_pkg::LEN_W-1:0] load_len;
  logic [TAB_BITS_W-1:0]     load_bits;
  logic [ACC_W-1:0]          acc;
  logic [hbp_pkg::LEN_W-1:0] total;

  // ---------------------------------------------------------------------
  // input side: table write on load, registered table read on every item
  // ---------------------------------------------------------------------
  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_accept = in_valid && !in_stall;

  // saturate the length and drop code bits above it
  always_comb begin
    load_len  = (in_item.code_length > LEN_CAP) ? LEN_CAP : in_item.code_length;
    load_bits = in_item.code_word[TAB_BITS_W-1:0] &
                ~({TAB_BITS_W{1'b1}} << load_len);
    load_wr   = in_accept && (in_item.action == hbp_pkg::ACT_LOAD);
  end

  always_ff @(posedge clk) begin
    if (load_wr && (in_item.code_length != '0)) begin
      bits_mem[in_item.symbol] <= load_bits;
      len_mem[in_item.symbol]  <= load_len;
    end
    // a load followed at once by an encode of the same entry sees the new
    // code, since both touch the table at their own accept edge
    if (in_accept) begin
      s1_bits_r   <= bits_mem[in_item.symbol];
      s1_len_r    <= len_mem[in_item.symbol];
      s1_tvalid_r <= tab_valid_r[in_item.symbol];
      s1_action_r <= in_item.action;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tab_valid_r <= '0;
    end else if (load_wr) begin
      tab_valid_r[in_item.symbol] <= (in_item.code_length != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------
  // packer stage: shift-or the code above the held bits, cut off bytes
  // ---------------------------------------------------------------------
  // advance only when the queue can take the worst case of two results
  assign s1_adv = s1_valid_r && (cnt_r <= CNT_W'(FIFO_DEPTH - 2));

  always_comb begin
    acc      = ACC_W'(buf_r) | (ACC_W'(s1_bits_r) << fill_r);
    total    = hbp_pkg::LEN_W'(fill_r) + s1_len_r;
    buf_nxt  = buf_r;
    fill_nxt = fill_r;
    push_n   = 2'd0;
    res0     = '0;
    res1     = '0;
    // second byte of an encode is always the closing one
    res1.out_byte    = acc[15:8];
    res1.valid_bits  = 4'd8;
    res1.last_of_run = 1'b1;
    if (s1_adv) begin
      unique case (s1_action_r)
        hbp_pkg::ACT_ENCODE: begin
          if (!s1_tvalid_r) begin
            // missing code: error result, packer untouched
            push_n              = 2'd1;
            res0.unknown_symbol = 1'b1;
            res0.last_of_run    = 1'b1;
          end else begin
            res0.out_byte   = acc[7:0];
            res0.valid_bits = 4'd8;
            fill_nxt        = total[2:0];
            if (total >= hbp_pkg::LEN_W'(16)) begin
              push_n  = 2'd2;
              buf_nxt = acc[23:16];
            end else if (total >= hbp_pkg::LEN_W'(8)) begin
              push_n           = 2'd1;
              res0.last_of_run = 1'b1;
              buf_nxt          = acc[15:8];
            end else begin
              buf_nxt = acc[7:0];
            end
          end
        end
        hbp_pkg::ACT_FLUSH: begin
          if (fill_r != 3'd0) begin
            push_n           = 2'd1;
            res0.out_byte    = buf_r;
            res0.valid_bits  = {1'b0, fill_r};
            res0.last_of_run = 1'b1;
            buf_nxt          = 8'd0;
            fill_nxt         = 3'd0;
          end
        end
        default: begin
          // load already done at accept; unused action does nothing
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_r  <= 8'd0;
      fill_r <= 3'd0;
    end else begin
      buf_r  <= buf_nxt;
      fill_r <= fill_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // output queue: parts the packer from a stalled receiver
  // ---------------------------------------------------------------------
  assign out_valid = (cnt_r != '0);
  assign out_item  = fifo_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      fifo_r[wr_ptr_r] <= res0;
    end
    if (push_n == 2'd2) begin
      fifo_r[wr_ptr_r + PTR_W'(1)] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + PTR_W'(push_n);
      rd_ptr_r <= rd_ptr_r + PTR_W'(pop);
      cnt_r    <= cnt_r + CNT_W'(push_n) - CNT_W'(pop);
    end
  end

`ifndef SYNTHESIS
  // queue never overruns its depth
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(FIFO_DEPTH))
    else $error("output queue overrun");

  // a held packer stage keeps its item
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_action_r)))
    else $error("packer stage lost its item while stalled");

  // an unknown symbol leaves the packer as it was
  a_unknown_keep: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && (s1_action_r == hbp_pkg::ACT_ENCODE) && !s1_tvalid_r)
      |=> ($stable(buf_r) && $stable(fill_r)))
    else $error("unknown symbol changed the packer");

  // flush always empties the packer
  a_flush_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && (s1_action_r == hbp_pkg::ACT_FLUSH))
      |=> ((fill_r == 3'd0) && (buf_r == 8'd0)))
    else $error("flush left bits in the packer");
`endif

endmodule

`default_nettype wire

@@ tb/tb_huffman_bit_packer.sv @@
// tb_huffman_bit_packer: self-checking testbench for the huffman bit packer
// drives directed and random load, encode and flush items and checks every result item
// depends on hbp_pkg and hdl/huffman_bit_packer.sv
`timescale 1ns / 1ps

module tb_huffman_bit_packer;
  import hbp_pkg::*;

  // tb-side codes and limits
  localparam logic [1:0] ACT_UNUSED     = 2'd3;
  localparam int         MAX_BITS       = DEF_MAX_CODE_BITS;
  localparam logic [3:0] FULL_BYTE_BITS = 4'd8;
  localparam int         RANDOM_ITEMS   = 780;
  localparam int         IDLE_PERCENT   = 14;
  localparam int         HOLD_CYCLES    = 300;
  localparam int         TAIL_CYCLES    = 16;
  localparam int         WATCHDOG_LIMIT = 2000;
  localparam int         MAX_ROWS       = 32;

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // block ports, the driven inputs known from time zero
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  huffman_bit_packer #(
    .MAX_CODE_BITS(MAX_BITS)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  // shadow of the code table and the byte packer
  logic [15:0] code_bits [TABLE_DEPTH];
  logic [4:0]  code_len  [TABLE_DEPTH];
  bit          code_ok   [TABLE_DEPTH];
  logic [7:0]  acc_byte;
  logic [2:0]  acc_fill;

  out_item_t predicted [$];     // bytes caused by the item just accepted
  out_item_t pending_bytes [$]; // result items still owed by the block

  // idling and back-pressure controls
  bit tx_idle_on    = 1'b1;
  bit rx_idle_on    = 1'b1;
  bit pressure_go   = 1'b0;
  bit pressure_done = 1'b0;
  int hold_left     = 0;

  // bookkeeping
  int errors      = 0;
  int quiet_count = 0;
  int n_loads     = 0;
  int n_encodes   = 0;
  int n_flushes   = 0;
  int n_noise     = 0;
  int n_results   = 0;
  int n_unknown   = 0;
  int n_partial   = 0;

  // directed stimulus table
  typedef struct {
    in_item_t  item;
    bit        typed;   // expected results typed in below rather than predicted
    int        n_res;
    out_item_t res0;
    out_item_t res1;
  } dir_row_t;

  dir_row_t dir_rows [MAX_ROWS];
  int       n_rows = 0;

  function automatic in_item_t mk_in(logic [1:0] act, logic [7:0] sym,
                                     logic [15:0] word, logic [4:0] len);
    in_item_t it;
    it.action      = act;
    it.symbol      = sym;
    it.code_word   = word;
    it.code_length = len;
    return it;
  endfunction

  function automatic out_item_t mk_res(logic [7:0] b, logic [3:0] nb, logic unk,
                                       logic last);
    out_item_t r;
    r.out_byte       = b;
    r.valid_bits     = nb;
    r.unknown_symbol = unk;
    r.last_of_run    = last;
    return r;
  endfunction

  task automatic add_row(logic [1:0] act, logic [7:0] sym, logic [15:0] word,
                         logic [4:0] len, bit typed, int n, out_item_t r0,
                         out_item_t r1);
    dir_rows[n_rows].item  = mk_in(act, sym, word, len);
    dir_rows[n_rows].typed = typed;
    dir_rows[n_rows].n_res = n;
    dir_rows[n_rows].res0  = r0;
    dir_rows[n_rows].res1  = r1;
    n_rows++;
  endtask

  // predictor: applies one item to the shadow table and packer and leaves the
  // bytes it causes in predicted
  task automatic predict_pack(input in_item_t it);
    logic [23:0] acc;
    int          total;
    int          n;
    int          len;
    predicted.delete();
    case (it.action)
      ACT_LOAD: begin
        if (it.code_length == 5'd0) begin
          // zero length clears the entry
          code_ok[it.symbol]   = 1'b0;
          code_bits[it.symbol] = '0;
          code_len[it.symbol]  = '0;
        end else begin
          // overlong lengths saturate, bits above the length are dropped
          len = int'(it.code_length);
          if (len > MAX_BITS) len = MAX_BITS;
          if (len > 16) len = 16;
          code_bits[it.symbol] = it.code_word & 16'((32'd1 << len) - 1);
          code_len[it.symbol]  = 5'(len);
          code_ok[it.symbol]   = 1'b1;
        end
      end
      ACT_ENCODE: begin
        if (!code_ok[it.symbol]) begin
          // no code loaded: error item, packer left as it was
          predicted.push_back(mk_res(8'd0, 4'd0, 1'b1, 1'b1));
        end else begin
          acc   = ({8'd0, code_bits[it.symbol]} << acc_fill) | {16'd0, acc_byte};
          total = int'(acc_fill) + int'(code_len[it.symbol]);
          n     = 0;
          while (total >= 8 && n < 2) begin
            // last unless a second full byte follows
            predicted.push_back(mk_res(acc[7:0], FULL_BYTE_BITS, 1'b0,
                                       !(total >= 16 && n == 0)));
            acc   = acc >> 8;
            total = total - 8;
            n++;
          end
          acc_byte = acc[7:0];
          acc_fill = 3'(total);
        end
      end
      ACT_FLUSH: begin
        // an empty packer flushes to nothing
        if (acc_fill != 3'd0) begin
          predicted.push_back(mk_res(acc_byte, {1'b0, acc_fill}, 1'b0, 1'b1));
          acc_byte = '0;
          acc_fill = '0;
        end
      end
      default: ;
    endcase
  endtask

  // sender: random idle cycles, then hold the item until it is taken
  task automatic send_item(input in_item_t it);
    while (tx_idle_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_item  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    case (it.action)
      ACT_LOAD:   n_loads++;
      ACT_ENCODE: n_encodes++;
      ACT_FLUSH:  n_flushes++;
      default:    n_noise++;
    endcase
  endtask

  // receiver: random stalls, plus one long hold counted out here
  initial begin
    forever begin
      @(posedge clk);
      if (pressure_go && !pressure_done) begin
        hold_left     = HOLD_CYCLES;
        pressure_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= rx_idle_on && ($urandom_range(0, 99) < IDLE_PERCENT);
      end
    end
  end

  // result checker: every accepted result against the oldest owed one
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (out_item.unknown_symbol === 1'b1) n_unknown++;
      if (out_item.valid_bits !== FULL_BYTE_BITS && out_item.unknown_symbol === 1'b0)
        n_partial++;
      if (pending_bytes.size() == 0) begin
        errors++;
        $display("%0t: unexpected result item byte=%h bits=%0d unknown=%b last=%b",
                 $time, out_item.out_byte, out_item.valid_bits,
                 out_item.unknown_symbol, out_item.last_of_run);
      end else begin
        if (out_item.out_byte !== pending_bytes[0].out_byte ||
            out_item.valid_bits !== pending_bytes[0].valid_bits ||
            out_item.unknown_symbol !== pending_bytes[0].unknown_symbol ||
            out_item.last_of_run !== pending_bytes[0].last_of_run) begin
          errors++;
          $display("%0t: mismatch byte/bits/unknown/last expected %h/%0d/%b/%b, got %h/%0d/%b/%b",
                   $time, pending_bytes[0].out_byte, pending_bytes[0].valid_bits,
                   pending_bytes[0].unknown_symbol, pending_bytes[0].last_of_run,
                   out_item.out_byte, out_item.valid_bits,
                   out_item.unknown_symbol, out_item.last_of_run);
        end
        void'(pending_bytes.pop_front());
      end
    end
  end

  // watchdog: cycles in which no item moves on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_count <= 0;
    end else begin
      quiet_count <= quiet_count + 1;
    end
    if (quiet_count == WATCHDOG_LIMIT) begin
      $display("%0t: watchdog, no item moved for %0d cycles, %0d results owed",
               $time, WATCHDOG_LIMIT, pending_bytes.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // main sequence
  initial begin
    in_item_t it;
    int       counted;
    int       r;
    int       k;
    logic [7:0] sym;

    for (k = 0; k < TABLE_DEPTH; k++) code_ok[k] = 1'b0;
    acc_byte = '0;
    acc_fill = '0;

    // directed rows: typed ones are the after-reset, extreme and error cases
    // unknown symbol straight after reset
    add_row(ACT_ENCODE, 8'h00, 16'h0000, 5'd0, 1, 1, mk_res(8'h00, 4'd0, 1, 1), '0);
    // empty flush, then an ignored action with every field bit set
    add_row(ACT_FLUSH, 8'h00, 16'h0000, 5'd0, 1, 0, '0, '0);
    add_row(ACT_UNUSED, 8'hFF, 16'hFFFF, 5'd31, 1, 0, '0, '0);
    // longest code gives two full bytes
    add_row(ACT_LOAD, 8'hFF, 16'hFFFF, 5'd16, 1, 0, '0, '0);
    add_row(ACT_ENCODE, 8'hFF, 16'h0000, 5'd0, 1, 2,
            mk_res(8'hFF, FULL_BYTE_BITS, 0, 0), mk_res(8'hFF, FULL_BYTE_BITS, 0, 1));
    // overlong length saturates to sixteen
    add_row(ACT_LOAD, 8'h00, 16'hFFFF, 5'd31, 1, 0, '0, '0);
    add_row(ACT_ENCODE, 8'h00, 16'h0000, 5'd0, 1, 2,
            mk_res(8'hFF, FULL_BYTE_BITS, 0, 0), mk_res(8'hFF, FULL_BYTE_BITS, 0, 1));
    // one-bit code, high code bits dropped; no full byte, then a partial flush
    add_row(ACT_LOAD, 8'h01, 16'hFFFF, 5'd1, 1, 0, '0, '0);
    add_row(ACT_ENCODE, 8'h01, 16'h0000, 5'd0, 1, 0, '0, '0);
    add_row(ACT_FLUSH, 8'h00, 16'h0000, 5'd0, 1, 1, mk_res(8'h01, 4'd1, 0, 1), '0);
    // exactly one byte from an empty packer
    add_row(ACT_LOAD, 8'h80, 16'h00AA, 5'd8, 1, 0, '0, '0);
    add_row(ACT_ENCODE, 8'h80, 16'h0000, 5'd0, 1, 1,
            mk_res(8'hAA, FULL_BYTE_BITS, 0, 1), '0);
    // clearing an entry makes it unknown again
    add_row(ACT_LOAD, 8'h00, 16'h0000, 5'd0, 1, 0, '0, '0);
    add_row(ACT_ENCODE, 8'h00, 16'h0000, 5'd0, 1, 1, mk_res(8'h00, 4'd0, 1, 1), '0);
    // predicted rows: codes straddling bytes, unknown symbol mid-stream
    add_row(ACT_LOAD, 8'h03, 16'h5A5A, 5'd13, 0, 0, '0, '0);
    add_row(ACT_ENCODE, 8'h01, 16'h0000, 5'd0, 0, 0, '0, '0);
    add_row(ACT_ENCODE, 8'h03, 16'h0000, 5'd0, 0, 0, '0, '0);
    add_row(ACT_ENCODE, 8'h7F, 16'h0000, 5'd0, 0, 0, '0, '0);
    add_row(ACT_LOAD, 8'h10, 16'h1234, 5'd16, 0, 0, '0, '0);
    add_row(ACT_ENCODE, 8'h10, 16'h0000, 5'd0, 0, 0, '0, '0);
    add_row(ACT_ENCODE, 8'hFF, 16'h0000, 5'd0, 0, 0, '0, '0);
    add_row(ACT_LOAD, 8'h11, 16'h0000, 5'd17, 0, 0, '0, '0);
    add_row(ACT_ENCODE, 8'h11, 16'h0000, 5'd0, 0, 0, '0, '0);
    add_row(ACT_FLUSH, 8'h00, 16'h0000, 5'd0, 0, 0, '0, '0);
    add_row(ACT_FLUSH, 8'h00, 16'h0000, 5'd0, 0, 0, '0, '0);

    // synchronous reset, held low and then released
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // walk the directed table
    for (k = 0; k < n_rows; k++) begin
      send_item(dir_rows[k].item);
      predict_pack(dir_rows[k].item);
      if (dir_rows[k].typed) begin
        if (dir_rows[k].n_res > 0) pending_bytes.push_back(dir_rows[k].res0);
        if (dir_rows[k].n_res > 1) pending_bytes.push_back(dir_rows[k].res1);
      end else begin
        foreach (predicted[i]) pending_bytes.push_back(predicted[i]);
      end
    end

    // random part: table fill first, then mostly encodes of loaded symbols
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      // a quiet stretch with no idling on either side, then the long hold
      if (counted == 300) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end
      if (counted == 500) begin
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
      end
      if (counted == 600) pressure_go = 1'b1;

      r = (counted < 40) ? 0 : $urandom_range(0, 99);
      if (r < 12) begin
        it.action    = ACT_LOAD;
        it.symbol    = 8'($urandom_range(0, 255));
        it.code_word = 16'($urandom_range(0, 65535));
        k = $urandom_range(0, 19);
        if (counted < 40)  it.code_length = 5'($urandom_range(1, 16));
        else if (k < 2)    it.code_length = 5'd0;
        else if (k < 4)    it.code_length = 5'($urandom_range(17, 31));
        else               it.code_length = 5'($urandom_range(1, 16));
      end else if (r < 80) begin
        // mostly symbols that hold a code, now and then any symbol at all
        sym = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 9) != 0) begin
          for (k = 0; k < 16 && !code_ok[sym]; k++) sym = 8'($urandom_range(0, 255));
        end
        it = mk_in(ACT_ENCODE, sym, 16'($urandom_range(0, 65535)),
                   5'($urandom_range(0, 31)));
      end else if (r < 94) begin
        it = mk_in(ACT_FLUSH, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                   5'($urandom_range(0, 31)));
      end else begin
        it = mk_in(ACT_UNUSED, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                   5'($urandom_range(0, 31)));
      end

      send_item(it);
      predict_pack(it);
      foreach (predicted[i]) pending_bytes.push_back(predicted[i]);
      if (it.action != ACT_UNUSED) counted++;
    end
    in_valid <= 1'b0;

    // drain, then a short tail to catch stray results
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_bytes.size() != 0) begin
      errors++;
      $display("%0t: %0d result items never arrived", $time, pending_bytes.size());
    end

    $display("items sent: %0d loads, %0d encodes, %0d flushes, %0d ignored actions",
             n_loads, n_encodes, n_flushes, n_noise);
    $display("result items checked: %0d, of them %0d unknown-symbol and %0d partial bytes",
             n_results, n_unknown, n_partial);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
